// ===== rtl/cemap_pkg.sv =====
// ----------------------------------------------------------------------------
// cemap_pkg
// Shared types, constants and the arctangent step constants for the
// cube face to equirectangular coordinate map.
// ----------------------------------------------------------------------------
package cemap_pkg;

   localparam int COORD_BITS    = 12;
   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int OUT_FRAC_BITS = 8;
   localparam int CORDIC_N      = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

   localparam longint Q30_SHIFT    = 30 - FRAC_BITS;
   localparam longint PI_Q30       = 64'sd3373259426;
   localparam longint PI_Q         = (PI_Q30 + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
   localparam longint HALF_PI_Q    = PI_Q / 2;
   localparam longint INV_GAIN_Q30 = 64'sd652032874;
   localparam longint ONE_Q        = 64'sd1 <<< FRAC_BITS;
   localparam longint OUT_MAX      = 64'sd2097151;

   // datapath widths
   localparam int NRM_W  = FRAC_BITS + 2;   // nx, ny: +-(2 - lsb)
   localparam int CW     = FRAC_BITS + 8;   // cordic x, y
   localparam int ZW     = FRAC_BITS + 5;   // cordic angle
   localparam int DNUM_W = 35;
   localparam int DDEN_W = 18;
   localparam int DQ_W   = 20;
   localparam int UN_W   = 23;
   localparam int TW     = FRAC_BITS + 1;

   // register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_EXTENT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_DEPTH   = 3'd5;

   // face codes
   localparam logic [2:0] FACE_YAW_HALF = 3'd0;
   localparam logic [2:0] FACE_YAW_ONE  = 3'd1;
   localparam logic [2:0] FACE_YAW_NEG  = 3'd2;
   localparam logic [2:0] FACE_TOP      = 3'd4;
   localparam logic [2:0] FACE_BOTTOM   = 3'd5;

   typedef struct packed {
      logic [2:0]  face_id;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [20:0] source_col;
      logic [20:0] source_row;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [2:0]              face;
      logic signed [NRM_W-1:0] ny;
      logic signed [ZW-1:0]    ang;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic              neg;
      logic [DNUM_W-1:0] num;
      logic [DDEN_W-1:0] den;
   } div_in_type;

   typedef struct packed {
      side_type        side;
      logic            neg;
      logic            sat;
      logic [DQ_W-1:0] quo;
   } div_out_type;

   typedef struct packed {
      side_type             side;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } cord_in_type;

   typedef struct packed {
      side_type             side;
      logic signed [ZW-1:0] z;
      logic signed [CW-1:0] mag;
   } cord_out_type;

   function automatic logic signed [ZW-1:0] atan_q(input int i);
      longint t;
      case (i)
         0:  t = 843314857;
         1:  t = 497837829;
         2:  t = 263043836;
         3:  t = 133525158;
         4:  t = 67021686;
         5:  t = 33543515;
         6:  t = 16775850;
         7:  t = 8388437;
         8:  t = 4194282;
         9:  t = 2097149;
         10: t = 1048575;
         11: t = 524287;
         12: t = 262143;
         13: t = 131071;
         14: t = 65535;
         15: t = 32767;
         16: t = 16383;
         17: t = 8191;
         18: t = 4095;
         19: t = 2047;
         20: t = 1024;
         21: t = 512;
         22: t = 256;
         23: t = 128;
         default: t = 0;
      endcase
      return ZW'((t + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT);
   endfunction

endpackage

// ===== rtl/cemap_div.sv =====
// ----------------------------------------------------------------------------
// cemap_div
// Pipelined restoring divider, one quotient bit per stage, magnitude in and
// out with a sign and a side payload carried along. Flags quotient overflow.
// ----------------------------------------------------------------------------
module cemap_div (
   input  logic                   clock,
   input  logic                   reset,
   input  cemap_pkg::div_in_type  div_i,
   output cemap_pkg::div_out_type div_o
);
   import cemap_pkg::*;

   localparam int CMP_W = DDEN_W + DQ_W + 1;

   typedef struct packed {
      side_type          side;
      logic              neg;
      logic              sat;
      logic [DNUM_W-1:0] rem;
      logic [DDEN_W-1:0] den;
      logic [DQ_W-1:0]   quo;
   } div_stage_type;

   div_stage_type st_ff [DQ_W+1];
   div_stage_type st0_in;

   always_comb begin
      st0_in.side = div_i.side;
      st0_in.neg  = div_i.neg;
      st0_in.sat  = CMP_W'(div_i.num) >= (CMP_W'(div_i.den) << DQ_W);
      st0_in.rem  = div_i.num;
      st0_in.den  = div_i.den;
      st0_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].side.valid <= 1'b0;
      end else begin
         st_ff[0] <= st0_in;
      end
   end

   for (genvar g = 0; g < DQ_W; g++) begin : gen_step
      localparam int K = DQ_W - 1 - g;
      logic [CMP_W-1:0] sub;
      div_stage_type    nxt_in;

      assign sub = CMP_W'(st_ff[g].den) << K;

      always_comb begin
         nxt_in = st_ff[g];
         if (CMP_W'(st_ff[g].rem) >= sub) begin
            nxt_in.rem    = st_ff[g].rem - DNUM_W'(sub);
            nxt_in.quo[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g+1].side.valid <= 1'b0;
         end else begin
            st_ff[g+1] <= nxt_in;
         end
      end
   end

   assign div_o.side = st_ff[DQ_W].side;
   assign div_o.neg  = st_ff[DQ_W].neg;
   assign div_o.sat  = st_ff[DQ_W].sat;
   assign div_o.quo  = st_ff[DQ_W].quo;

endmodule

// ===== rtl/cemap_cordic.sv =====
// ----------------------------------------------------------------------------
// cemap_cordic
// Pipelined CORDIC vectoring: atan2(y, x) and gain-corrected magnitude,
// one micro-rotation per stage, side payload carried along.
// ----------------------------------------------------------------------------
module cemap_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  cemap_pkg::cord_in_type  cord_i,
   output cemap_pkg::cord_out_type cord_o
);
   import cemap_pkg::*;

   localparam int GW = 31;
   localparam logic signed [GW-1:0] INV_GAIN = GW'(INV_GAIN_Q30);

   typedef struct packed {
      side_type             side;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cord_stage_type;

   cord_stage_type st_ff [CORDIC_N+1];
   cord_stage_type pre_in;
   logic signed [CW-1:0] xi, yi;

   assign xi = cord_i.x;
   assign yi = cord_i.y;

   // left half plane: fold by a half turn
   always_comb begin
      pre_in.side = cord_i.side;
      pre_in.x    = xi;
      pre_in.y    = yi;
      pre_in.z    = '0;
      if (xi < 0) begin
         pre_in.x = -xi;
         pre_in.y = -yi;
         pre_in.z = (yi >= 0) ? ZW'(PI_Q) : ZW'(-PI_Q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].side.valid <= 1'b0;
      end else begin
         st_ff[0] <= pre_in;
      end
   end

   for (genvar g = 0; g < CORDIC_N; g++) begin : gen_stage
      logic signed [CW-1:0] x_s, y_s, xs, ys;
      logic signed [ZW-1:0] z_s, a_s;
      cord_stage_type       nxt_in;

      assign x_s = st_ff[g].x;
      assign y_s = st_ff[g].y;
      assign z_s = st_ff[g].z;
      assign xs  = x_s >>> g;
      assign ys  = y_s >>> g;
      assign a_s = atan_q(g);

      always_comb begin
         nxt_in.side = st_ff[g].side;
         if (y_s >= 0) begin
            nxt_in.x = x_s + ys;
            nxt_in.y = y_s - xs;
            nxt_in.z = z_s + a_s;
         end else begin
            nxt_in.x = x_s - ys;
            nxt_in.y = y_s + xs;
            nxt_in.z = z_s - a_s;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g+1].side.valid <= 1'b0;
         end else begin
            st_ff[g+1] <= nxt_in;
         end
      end
   end

   logic signed [CW-1:0]    x_last;
   logic signed [CW+GW-1:0] prod_in, prod_ff;
   logic signed [ZW-1:0]    z_ff;
   side_type                side_ff;

   assign x_last  = st_ff[CORDIC_N].x;
   assign prod_in = (CW+GW)'(x_last) * (CW+GW)'(INV_GAIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff <= st_ff[CORDIC_N].side;
      end
      prod_ff <= prod_in;
      z_ff    <= st_ff[CORDIC_N].z;
   end

   assign cord_o.side = side_ff;
   assign cord_o.z    = z_ff;
   assign cord_o.mag  = prod_ff[30 +: CW];

endmodule

// ===== rtl/cubemap_to_equirect_coord_map.sv =====
// ----------------------------------------------------------------------------
// cubemap_to_equirect_coord_map
// Maps a cube face pixel to its sampling position in an equirectangular
// source image: normalise, scale by plane extent, two CORDIC vectorings,
// angle normalisation, wrap, scale to source pixels.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is never raised.
// The normalisation divider (one bit a stage) and the two CORDIC chains set the depth.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous reset clears the pipeline valids and loads register defaults.
// ----------------------------------------------------------------------------
module cubemap_to_equirect_coord_map (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  cemap_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   output cemap_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cemap_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cemap_pkg::CSR_DATA_W-1:0]      csr_data
);
   import cemap_pkg::*;

   localparam logic signed [UN_W-1:0]  ONE_S   = UN_W'(ONE_Q);
   localparam logic signed [UN_W-1:0]  TWO_S   = UN_W'(2 * ONE_Q);
   localparam logic signed [UN_W-1:0]  HALF_S  = UN_W'(ONE_Q / 2);
   localparam logic [DQ_W-1:0]         NRM_SAT = DQ_W'(4 * ONE_Q);
   localparam logic signed [NRM_W+3:0] EXT_MAX = (NRM_W+4)'(2 * ONE_Q - 1);
   localparam int PW = TW + 14;
   localparam int RW = PW + OUT_FRAC_BITS + 1;

   // ---------------- configuration ----------------
   logic [12:0] face_width_ff, face_height_ff;
   logic [13:0] source_width_ff, source_height_ff;
   logic [16:0] plane_extent_ff, plane_depth_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff    <= 13'd1024;
         face_height_ff   <= 13'd1024;
         source_width_ff  <= 14'd4096;
         source_height_ff <= 14'd2048;
         plane_extent_ff  <= 17'd46341;
         plane_depth_ff   <= 17'd46341;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FACE_WIDTH:    face_width_ff    <= csr_data[12:0];
            CSR_FACE_HEIGHT:   face_height_ff   <= csr_data[12:0];
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_data[13:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_data[13:0];
            CSR_PLANE_EXTENT:  plane_extent_ff  <= csr_data;
            CSR_PLANE_DEPTH:   plane_depth_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Q1.16 registers equal the internal format at 16 fraction bits
   logic [12:0]          fw, fh;
   logic [16:0]          ak;
   logic [13:0]          scale_col, scale_row;

   assign fw        = (face_width_ff == '0) ? 13'd1 : face_width_ff;
   assign fh        = (face_height_ff == '0) ? 13'd1 : face_height_ff;
   assign ak        = (plane_depth_ff == '0) ? 17'd1 : plane_depth_ff;
   assign scale_col = (source_width_ff == '0) ? 14'd0 : source_width_ff - 14'd1;
   assign scale_row = (source_height_ff == '0) ? 14'd0 : source_height_ff - 14'd1;

   // ---------------- input register ----------------
   logic    s0_valid_ff;
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   // ---------------- normalisation ----------------
   logic signed [13:0] num_x, num_y;
   logic [13:0]        mag_x, mag_y;
   div_in_type         dnx_in, dny_in;
   div_out_type        dnx_out, dny_out;

   assign num_x = $signed({1'b0, req_ff.pixel_y[COORD_BITS-1:0], 1'b0}) - $signed({1'b0, fh});
   assign num_y = $signed({1'b0, req_ff.pixel_x[COORD_BITS-1:0], 1'b0}) - $signed({1'b0, fw});
   assign mag_x = (num_x < 0) ? 14'(-num_x) : 14'(num_x);
   assign mag_y = (num_y < 0) ? 14'(-num_y) : 14'(num_y);

   always_comb begin
      dnx_in.side.valid = s0_valid_ff;
      dnx_in.side.face  = req_ff.face_id;
      dnx_in.side.ny    = '0;
      dnx_in.side.ang   = '0;
      dnx_in.neg        = num_x < 0;
      dnx_in.num        = DNUM_W'(mag_x) << FRAC_BITS;
      dnx_in.den        = DDEN_W'(fh);
      dny_in.side       = '0;
      dny_in.neg        = num_y < 0;
      dny_in.num        = DNUM_W'(mag_y) << FRAC_BITS;
      dny_in.den        = DDEN_W'(fw);
   end

   cemap_div u_div_nx (.clock(clock), .reset(reset), .div_i(dnx_in), .div_o(dnx_out));
   cemap_div u_div_ny (.clock(clock), .reset(reset), .div_i(dny_in), .div_o(dny_out));

   // ---------------- extent scaling ----------------
   logic [DQ_W-1:0]          qx_m, qy_m;
   logic signed [DQ_W-1:0]   qx_s, qy_s;
   logic signed [DQ_W+17:0]  mx_in, my_in, mx_ff, my_ff;
   side_type                 m_side_ff;

   assign qx_m  = (dnx_out.sat || dnx_out.quo > NRM_SAT) ? NRM_SAT : dnx_out.quo;
   assign qy_m  = (dny_out.sat || dny_out.quo > NRM_SAT) ? NRM_SAT : dny_out.quo;
   assign qx_s  = dnx_out.neg ? -$signed(qx_m) : $signed(qx_m);
   assign qy_s  = dny_out.neg ? -$signed(qy_m) : $signed(qy_m);
   assign mx_in = (DQ_W+18)'(qx_s) * $signed({1'b0, plane_extent_ff});
   assign my_in = (DQ_W+18)'(qy_s) * $signed({1'b0, plane_extent_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_side_ff.valid <= 1'b0;
      end else begin
         m_side_ff <= dnx_out.side;
      end
      mx_ff <= mx_in;
      my_ff <= my_in;
   end

   logic signed [NRM_W+3:0] sx, sy;
   logic signed [NRM_W-1:0] nx_in, ny_in, nx_ff, ny_ff;
   side_type                c_side_ff;

   assign sx    = (NRM_W+4)'(mx_ff >>> FRAC_BITS);
   assign sy    = (NRM_W+4)'(my_ff >>> FRAC_BITS);
   assign nx_in = (sx > EXT_MAX) ? NRM_W'(EXT_MAX) :
                  (sx < -EXT_MAX) ? NRM_W'(-EXT_MAX) : NRM_W'(sx);
   assign ny_in = (sy > EXT_MAX) ? NRM_W'(EXT_MAX) :
                  (sy < -EXT_MAX) ? NRM_W'(-EXT_MAX) : NRM_W'(sy);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_side_ff.valid <= 1'b0;
      end else begin
         c_side_ff <= m_side_ff;
      end
      nx_ff <= nx_in;
      ny_ff <= ny_in;
   end

   // ---------------- first vectoring ----------------
   logic        pole_a, pole_b;
   cord_in_type ca_in, cb_in;
   cord_out_type ca_out, cb_out;

   assign pole_a = (c_side_ff.face == FACE_TOP) || (c_side_ff.face == FACE_BOTTOM);

   always_comb begin
      ca_in.side    = c_side_ff;
      ca_in.side.ny = ny_ff;
      if (pole_a) begin
         ca_in.x = CW'(nx_ff);
         ca_in.y = (c_side_ff.face == FACE_BOTTOM) ? CW'(ny_ff) : -CW'(ny_ff);
      end else begin
         ca_in.x = CW'($signed({1'b0, ak}));
         ca_in.y = CW'(nx_ff);
      end
   end

   cemap_cordic u_cordic_a (.clock(clock), .reset(reset), .cord_i(ca_in), .cord_o(ca_out));

   // ---------------- second vectoring ----------------
   assign pole_b = (ca_out.side.face == FACE_TOP) || (ca_out.side.face == FACE_BOTTOM);

   always_comb begin
      cb_in.side     = ca_out.side;
      cb_in.side.ang = ca_out.z;
      if (pole_b) begin
         cb_in.x = CW'($signed({1'b0, ak}));
         cb_in.y = ca_out.mag;
      end else begin
         cb_in.x = ca_out.mag;
         cb_in.y = CW'(ca_out.side.ny);
      end
   end

   cemap_cordic u_cordic_b (.clock(clock), .reset(reset), .cord_i(cb_in), .cord_o(cb_out));

   // ---------------- angle normalisation ----------------
   // divide by pi: reciprocal multiply, then one correction step
   localparam int AW  = ZW + 1;
   localparam int RMW = AW + FRAC_BITS;
   localparam logic [AW-1:0]     RECIP = AW'((64'sd1 <<< (FRAC_BITS + AW)) / PI_Q);
   localparam logic [DDEN_W-1:0] PI_U  = DDEN_W'(PI_Q);

   logic signed [ZW-1:0]   ua, va;
   logic [ZW-1:0]          ua_m, va_m;
   logic [AW-1:0]          au_ff, av_ff, au1_ff, av1_ff, qu1_ff, qv1_ff, qu2_ff, qv2_ff;
   logic                   nu_ff, nv_ff, nu1_ff, nv1_ff, nu2_ff, nv2_ff;
   logic [2*AW-1:0]        pu_in, pv_in;
   logic [RMW-1:0]         ru_in, rv_in;
   logic [DDEN_W:0]        ru2_ff, rv2_ff;
   logic [AW-1:0]          qu_fix, qv_fix;
   logic signed [UN_W-1:0] un_q_ff, vn_q_ff;
   side_type               a0_side_ff, a1_side_ff, a2_side_ff, a3_side_ff;

   assign ua = cb_out.side.ang;

   always_comb begin
      case (cb_out.side.face)
         FACE_TOP:    va = cb_out.z - ZW'(HALF_PI_Q);
         FACE_BOTTOM: va = ZW'(HALF_PI_Q) - cb_out.z;
         default:     va = cb_out.z;
      endcase
   end

   assign ua_m = (ua < 0) ? ZW'(-ua) : ZW'(ua);
   assign va_m = (va < 0) ? ZW'(-va) : ZW'(va);

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_side_ff.valid <= 1'b0;
      end else begin
         a0_side_ff <= cb_out.side;
      end
      au_ff <= AW'(ua_m);
      av_ff <= {va_m, 1'b0};
      nu_ff <= ua < 0;
      nv_ff <= va < 0;
   end

   assign pu_in = (2*AW)'(au_ff) * (2*AW)'(RECIP);
   assign pv_in = (2*AW)'(av_ff) * (2*AW)'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_side_ff.valid <= 1'b0;
      end else begin
         a1_side_ff <= a0_side_ff;
      end
      au1_ff <= au_ff;
      av1_ff <= av_ff;
      nu1_ff <= nu_ff;
      nv1_ff <= nv_ff;
      qu1_ff <= pu_in[AW +: AW];
      qv1_ff <= pv_in[AW +: AW];
   end

   assign ru_in = (RMW'(au1_ff) << FRAC_BITS) - RMW'(qu1_ff) * RMW'(PI_U);
   assign rv_in = (RMW'(av1_ff) << FRAC_BITS) - RMW'(qv1_ff) * RMW'(PI_U);

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_side_ff.valid <= 1'b0;
      end else begin
         a2_side_ff <= a1_side_ff;
      end
      nu2_ff <= nu1_ff;
      nv2_ff <= nv1_ff;
      qu2_ff <= qu1_ff;
      qv2_ff <= qv1_ff;
      ru2_ff <= ru_in[DDEN_W:0];
      rv2_ff <= rv_in[DDEN_W:0];
   end

   assign qu_fix = qu2_ff + AW'(ru2_ff >= {1'b0, PI_U});
   assign qv_fix = qv2_ff + AW'(rv2_ff >= {1'b0, PI_U});

   always_ff @(posedge clock) begin
      if (reset) begin
         a3_side_ff.valid <= 1'b0;
      end else begin
         a3_side_ff <= a2_side_ff;
      end
      un_q_ff <= nu2_ff ? -UN_W'(qu_fix) : UN_W'(qu_fix);
      vn_q_ff <= nv2_ff ? -UN_W'(qv_fix) : UN_W'(qv_fix);
   end

   // ---------------- yaw, wrap, texture ----------------
   logic signed [UN_W-1:0] yaw, un_y, vn_y, un_y_ff, vn_y_ff, un_w, tc, tr;
   logic                   w_valid_ff;
   logic [TW-1:0]          t_col_in, t_row_in, t_col_ff, t_row_ff;
   logic                   t_valid_ff;

   always_comb begin
      case (a3_side_ff.face)
         FACE_YAW_HALF: yaw = HALF_S;
         FACE_YAW_ONE:  yaw = ONE_S;
         FACE_YAW_NEG:  yaw = -HALF_S;
         default:       yaw = '0;
      endcase
   end

   always_comb begin
      un_y = un_q_ff + yaw;
      vn_y = vn_q_ff;
      if (vn_y < -ONE_S) begin
         vn_y = vn_y + TWO_S;
         un_y = un_y + ONE_S;
      end else if (vn_y > ONE_S) begin
         vn_y = vn_y - TWO_S;
         un_y = un_y + ONE_S;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else begin
         w_valid_ff <= a3_side_ff.valid;
      end
      un_y_ff <= un_y;
      vn_y_ff <= vn_y;
   end

   always_comb begin
      un_w = un_y_ff;
      for (int i = 0; i < 4; i++) begin
         if (un_w < -ONE_S) begin
            un_w = un_w + TWO_S;
         end else if (un_w > ONE_S) begin
            un_w = un_w - TWO_S;
         end
      end
      tc = (un_w + ONE_S) >>> 1;
      tr = (vn_y_ff + ONE_S) >>> 1;
      if (tc < 0) tc = '0;
      if (tc > ONE_S) tc = ONE_S;
      if (tr < 0) tr = '0;
      if (tr > ONE_S) tr = ONE_S;
      t_col_in = TW'(tc);
      t_row_in = TW'(tr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else begin
         t_valid_ff <= w_valid_ff;
      end
      t_col_ff <= t_col_in;
      t_row_ff <= t_row_in;
   end

   // ---------------- output scaling ----------------
   logic [PW-1:0] pc_ff, pr_ff;
   logic          p_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= t_valid_ff;
      end
      pc_ff <= PW'(t_col_ff) * PW'(scale_col);
      pr_ff <= PW'(t_row_ff) * PW'(scale_row);
   end

   logic [RW-1:0] rc, rr;
   logic [20:0]   col_in, row_in;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   assign rc     = ((RW'(pc_ff) << OUT_FRAC_BITS) + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
   assign rr     = ((RW'(pr_ff) << OUT_FRAC_BITS) + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
   assign col_in = (rc > RW'(OUT_MAX)) ? 21'(OUT_MAX) : rc[20:0];
   assign row_in = (rr > RW'(OUT_MAX)) ? 21'(OUT_MAX) : rr[20:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p_valid_ff;
      end
      rsp_ff.source_col <= col_in;
      rsp_ff.source_row <= row_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
